// ===== rtl/page_slot_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// page_slot_allocator_macros
// Assertion macros used by the page_slot_allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_SLOT_ALLOCATOR_MACROS_SVH
`define PAGE_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define PSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page_slot_allocator: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define PSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page_slot_allocator: next-cycle check failed");

`endif

// ===== rtl/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and helpers for the page slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int MAX_PAGES = 16;
    localparam int MAX_SLOTS = 64;
    localparam int PAGE_W    = 4;
    localparam int SLOT_W    = 6;
    localparam int USED_W    = 7;
    localparam int SPP_W     = 7;
    localparam int COUNT_W   = 10;
    localparam int GRP_SZ    = 8;
    localparam int GRP_CNT   = MAX_SLOTS / GRP_SZ;
    localparam int GRP_W     = 3;

    localparam logic [SPP_W-1:0] SPP_RESET = SPP_W'(64);

    // Request kinds
    typedef enum logic [0:0] {
        ACT_INSERT = 1'b0,
        ACT_DELETE = 1'b1
    } action_t;

    // Result codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Register indexes
    typedef enum logic [0:0] {
        REG_SLOTS_PER_PAGE = 1'b0
    } reg_idx_t;

    // One page's bookkeeping
    typedef struct packed {
        logic [MAX_SLOTS-1:0] slot_map;
        logic [USED_W-1:0]    used;
        logic [PAGE_W-1:0]    link;
        logic                 on_list;
    } page_entry_t;

    // Write request into the page table
    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
        page_entry_t       entry;
    } page_wr_t;

    // Index of the lowest clear bit of a byte; 0 if none
    function automatic logic [GRP_W-1:0] lowest_zero8(input logic [GRP_SZ-1:0] b);
        logic [GRP_W-1:0] idx;
        idx = '0;
        for (int i = GRP_SZ - 1; i >= 0; i--)
        begin
            if (!b[i])
            begin
                idx = GRP_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/psa_apb_regs.sv =====
// ----------------------------------------------------------------------------
// psa_apb_regs
// APB register bank holding the slots-per-page setting.
// ----------------------------------------------------------------------------
module psa_apb_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [2:0]                       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output logic [psa_pkg::SPP_W-1:0]        slots_per_page
);

    logic [psa_pkg::SPP_W-1:0] spp_reg;
    logic [psa_pkg::SPP_W-1:0] spp_next;
    logic                      hit;

    // word address decode
    assign hit = (paddr[2] == psa_pkg::REG_SLOTS_PER_PAGE);

    always_comb
    begin
        spp_next = spp_reg;
        if (psel && penable && pwrite && hit)
        begin
            spp_next = pwdata[psa_pkg::SPP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= psa_pkg::SPP_RESET;
        end
        else
        begin
            spp_reg <= spp_next;
        end
    end

    assign pready         = 1'b1;
    assign prdata         = hit ? {{(32 - psa_pkg::SPP_W){1'b0}}, spp_reg} : 32'd0;
    assign slots_per_page = spp_reg;

endmodule

// ===== rtl/psa_slot_find.sv =====
// ----------------------------------------------------------------------------
// psa_slot_find
// Lowest clear slot below the usable limit, as a two-level byte search.
// ----------------------------------------------------------------------------
module psa_slot_find
(
    input  logic [psa_pkg::MAX_SLOTS-1:0] slot_map,
    input  logic [psa_pkg::USED_W-1:0]    limit,
    output logic                          found,
    output logic [psa_pkg::SLOT_W-1:0]    slot
);

    logic [psa_pkg::MAX_SLOTS-1:0]  busy;
    logic [psa_pkg::GRP_CNT-1:0]    grp_free;
    logic [psa_pkg::GRP_W-1:0]      grp_idx [psa_pkg::GRP_CNT];
    logic [psa_pkg::GRP_W-1:0]      grp_sel;

    // slots at or above the limit count as taken
    always_comb
    begin
        for (int s = 0; s < psa_pkg::MAX_SLOTS; s++)
        begin
            busy[s] = slot_map[s] || (psa_pkg::USED_W'(s) >= limit);
        end
    end

    // per-byte search
    always_comb
    begin
        for (int g = 0; g < psa_pkg::GRP_CNT; g++)
        begin
            grp_free[g] = ~&busy[g*psa_pkg::GRP_SZ +: psa_pkg::GRP_SZ];
            grp_idx[g]  = psa_pkg::lowest_zero8(busy[g*psa_pkg::GRP_SZ +: psa_pkg::GRP_SZ]);
        end
    end

    // pick the lowest byte with room
    always_comb
    begin
        grp_sel = '0;
        for (int g = psa_pkg::GRP_CNT - 1; g >= 0; g--)
        begin
            if (grp_free[g])
            begin
                grp_sel = psa_pkg::GRP_W'(g);
            end
        end
    end

    assign found = |grp_free;
    assign slot  = {grp_sel, grp_idx[grp_sel]};

endmodule

// ===== rtl/psa_page_table.sv =====
// ----------------------------------------------------------------------------
// psa_page_table
// Per-page bitmap, used count, free-list link and on-list flag.
// ----------------------------------------------------------------------------
module psa_page_table
(
    input  logic                         clk,
    input  logic [psa_pkg::PAGE_W-1:0]   rd_page,
    output psa_pkg::page_entry_t         rd_entry,
    input  psa_pkg::page_wr_t            wr
);

    psa_pkg::page_entry_t pages_reg [psa_pkg::MAX_PAGES];

    // single read port
    assign rd_entry = pages_reg[rd_page];

    // whole-entry write; an entry is set up in full when its page opens
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pages_reg[wr.page] <= wr.entry;
        end
    end

endmodule

// ===== rtl/page_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// page_slot_allocator
// Heap-file slot allocator: per-page bitmaps with a free-page list.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake                 | Contents
//  s_axis   | in  | tvalid/tready             | insert or delete request
//  m_axis   | out | tvalid/tready             | status, page, slot, tuple count
//  APB      | in  | psel/penable/pwrite       | slots_per_page at 0x0
//
//  An input word is registered, resolved against the page table and lands
//  in the output register; one word per cycle sustained while the output
//  is not stalled. The critical path is the page table read mux, the
//  byte-wise free-slot search and the entry write-back.
//  Reset clears list head, open-page count, tuple count and valid flags; page
//  entries need no clearing since a page is fully written when it opens.
//  A stalled output holds its word and backpressure reaches s_axis_tready.
// ----------------------------------------------------------------------------
`include "page_slot_allocator_macros.svh"

module page_slot_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // page_in[3:0], slot_in[9:4], zero[15:10]
    input  logic [0:0]  s_axis_tuser,   // action[0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // page_out[3:0], slot_out[9:4],
                                        // tuple_count[19:10], zero[23:20]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int PW = psa_pkg::PAGE_W;
    localparam int SW = psa_pkg::SLOT_W;
    localparam int UW = psa_pkg::USED_W;
    localparam int CW = psa_pkg::COUNT_W;

    localparam logic [PW-1:0] LAST_PAGE = PW'(psa_pkg::MAX_PAGES - 1);

    // config
    logic [psa_pkg::SPP_W-1:0] slots_per_page;
    logic [UW-1:0]             limit;

    // input register
    logic                 in_valid_reg;
    psa_pkg::action_t     in_action_reg;
    logic [PW-1:0]        in_page_reg;
    logic [SW-1:0]        in_slot_reg;

    // output register
    logic                 out_valid_reg;
    psa_pkg::status_t     out_status_reg;
    logic [PW-1:0]        out_page_reg;
    logic [SW-1:0]        out_slot_reg;
    logic [CW-1:0]        out_count_reg;

    // file state
    logic [PW-1:0]        free_head_reg, free_head_next;
    logic [PW-1:0]        pages_open_reg, pages_open_next;
    logic [CW-1:0]        records_held_reg, records_held_next;

    // datapath
    logic                 fire;
    logic                 is_insert;
    logic                 list_empty;
    logic                 open_new;
    logic [PW-1:0]        tgt_page;
    psa_pkg::page_entry_t rd_entry;
    psa_pkg::page_entry_t cur;
    psa_pkg::page_wr_t    wr;
    logic                 found;
    logic [SW-1:0]        free_slot;
    logic [UW-1:0]        used_inc;
    logic                 bad_delete;
    psa_pkg::status_t     status_next;
    logic [PW-1:0]        page_out_next;
    logic [SW-1:0]        slot_out_next;

    psa_apb_regs u_regs
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .slots_per_page (slots_per_page)
    );

    // clamp usable slots to 1..MAX_SLOTS
    always_comb
    begin
        if (slots_per_page == '0)
        begin
            limit = UW'(1);
        end
        else if (slots_per_page > psa_pkg::SPP_W'(psa_pkg::MAX_SLOTS))
        begin
            limit = UW'(psa_pkg::MAX_SLOTS);
        end
        else
        begin
            limit = UW'(slots_per_page);
        end
    end

    // handshake
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    // page selection
    assign is_insert  = (in_action_reg == psa_pkg::ACT_INSERT);
    assign list_empty = (free_head_reg == '0);
    assign open_new   = is_insert && list_empty && (pages_open_reg != LAST_PAGE);

    always_comb
    begin
        if (!is_insert)
        begin
            tgt_page = in_page_reg;
        end
        else if (list_empty)
        begin
            tgt_page = pages_open_reg + PW'(1);
        end
        else
        begin
            tgt_page = free_head_reg;
        end
    end

    psa_page_table u_table
    (
        .clk      (clk),
        .rd_page  (tgt_page),
        .rd_entry (rd_entry),
        .wr       (wr)
    );

    // a freshly opened page starts empty
    assign cur = open_new ? '0 : rd_entry;

    psa_slot_find u_find
    (
        .slot_map (cur.slot_map),
        .limit    (limit),
        .found    (found),
        .slot     (free_slot)
    );

    assign used_inc   = cur.used + UW'(1);
    assign bad_delete = (in_page_reg == '0) || (in_page_reg > pages_open_reg)
                        || !cur.slot_map[in_slot_reg];

    // request resolution
    always_comb
    begin
        free_head_next    = free_head_reg;
        pages_open_next   = pages_open_reg;
        records_held_next = records_held_reg;
        wr.en             = 1'b0;
        wr.page           = tgt_page;
        wr.entry          = cur;
        status_next       = psa_pkg::ST_OK;
        page_out_next     = '0;
        slot_out_next     = '0;

        if (is_insert)
        begin
            if (list_empty && !open_new)
            begin
                // every page open, none with room
                status_next = psa_pkg::ST_FULL;
            end
            else if (!found)
            begin
                // head page has no usable slot after a limit change
                status_next          = psa_pkg::ST_FULL;
                free_head_next       = cur.link;
                wr.en                = 1'b1;
                wr.entry.on_list     = 1'b0;
            end
            else
            begin
                wr.en                        = 1'b1;
                wr.entry.slot_map[free_slot] = 1'b1;
                wr.entry.used                = used_inc;
                records_held_next            = records_held_reg + CW'(1);
                page_out_next                = tgt_page;
                slot_out_next                = free_slot;
                if (open_new)
                begin
                    pages_open_next = tgt_page;
                end
                if (used_inc >= limit)
                begin
                    free_head_next   = cur.link;
                    wr.entry.on_list = 1'b0;
                end
                else
                begin
                    free_head_next   = tgt_page;
                    wr.entry.on_list = 1'b1;
                end
            end
        end
        else
        begin
            if (bad_delete)
            begin
                status_next = psa_pkg::ST_BAD;
            end
            else
            begin
                wr.en                          = 1'b1;
                wr.entry.slot_map[in_slot_reg] = 1'b0;
                if (cur.used != '0)
                begin
                    wr.entry.used = cur.used - UW'(1);
                end
                if (records_held_reg != '0)
                begin
                    records_held_next = records_held_reg - CW'(1);
                end
                // full page goes back on the list head
                if ((cur.used >= limit) && !cur.on_list)
                begin
                    wr.entry.link    = free_head_reg;
                    wr.entry.on_list = 1'b1;
                    free_head_next   = tgt_page;
                end
            end
        end

        if (!fire)
        begin
            wr.en             = 1'b0;
            free_head_next    = free_head_reg;
            pages_open_next   = pages_open_reg;
            records_held_next = records_held_reg;
        end
    end

    // control and file state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            free_head_reg    <= '0;
            pages_open_reg   <= '0;
            records_held_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            free_head_reg    <= free_head_next;
            pages_open_reg   <= pages_open_next;
            records_held_reg <= records_held_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_action_reg <= psa_pkg::action_t'(s_axis_tuser[0]);
            in_page_reg   <= s_axis_tdata[PW-1:0];
            in_slot_reg   <= s_axis_tdata[PW +: SW];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= status_next;
            out_page_reg   <= page_out_next;
            out_slot_reg   <= slot_out_next;
            out_count_reg  <= records_held_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'd0, out_count_reg, out_slot_reg, out_page_reg};

    // list head is always zero or an open page
    `PSA_ASSERT_NOW(a_head_open, clk, rst_n, 1'b1, free_head_reg <= pages_open_reg)

    // a successful insert adds exactly one record
    `PSA_ASSERT_NEXT(a_insert_count, clk, rst_n,
                     fire && is_insert && (status_next == psa_pkg::ST_OK),
                     records_held_reg == $past(records_held_reg) + CW'(1))

    // failed requests never report a page
    `PSA_ASSERT_NOW(a_fail_no_page, clk, rst_n,
                    out_valid_reg && (out_status_reg != psa_pkg::ST_OK),
                    out_page_reg == '0)

endmodule
